FILE: src/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// shared types and constants of the trajectory breakpoint segmenter
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED = 2'd1;

  localparam int SQRT_W   = 68;
  localparam int SQRT_H   = SQRT_W / 2;
  localparam int SQRT_CW  = $clog2(SQRT_H + 1);

  localparam int DIV_NW   = 68;
  localparam int DIV_DW   = 48;
  localparam int DIV_CW   = $clog2(DIV_NW + 1);

  localparam int MUL_W    = 35;
  localparam int ACC_W    = 2 * MUL_W;

  localparam logic signed [MUL_W-1:0] US_PER_S = 35'sd1000000;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [33:0] wvec_t;
  typedef logic signed [15:0] unit_t;
  typedef logic [47:0]        time_t;

endpackage

FILE: src/tbs_if.sv
// ----------------------------------------------------------------------------
// tbs channel interfaces
// point, segment and configuration write channels
// ----------------------------------------------------------------------------
interface tbs_point_if;
  logic                valid;
  logic                ready;
  tbs_pkg::coord_t     pos_x;
  tbs_pkg::coord_t     pos_y;
  tbs_pkg::coord_t     pos_z;
  tbs_pkg::coord_t     vel_x;
  tbs_pkg::coord_t     vel_y;
  tbs_pkg::coord_t     vel_z;
  tbs_pkg::time_t      timestamp_us;
  logic                last_point;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  timestamp_us, last_point, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  timestamp_us, last_point, output ready);
endinterface

interface tbs_seg_if;
  logic                valid;
  logic                ready;
  logic [15:0]         seg_id;
  logic [15:0]         first_index;
  logic [15:0]         final_index;
  logic [47:0]         duration_us;
  logic [47:0]         path_length;
  logic [31:0]         mean_speed;
  tbs_pkg::unit_t      dir_x;
  tbs_pkg::unit_t      dir_y;
  tbs_pkg::unit_t      dir_z;
  logic                last_segment;
  modport source (output valid, seg_id, first_index, final_index, duration_us,
                  path_length, mean_speed, dir_x, dir_y, dir_z, last_segment,
                  input ready);
  modport sink   (input valid, seg_id, first_index, final_index, duration_us,
                  path_length, mean_speed, dir_x, dir_y, dir_z, last_segment,
                  output ready);
endinterface

interface tbs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbs_pkg::CFG_INDEX_W-1:0]   index;
  logic [31:0]                       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/tbs_sqrt.sv
// ----------------------------------------------------------------------------
// tbs_sqrt
// floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module tbs_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tbs_pkg::SQRT_W-1:0] radicand,
  output logic                       done,
  output logic [tbs_pkg::SQRT_H-1:0] root
);
  import tbs_pkg::*;

  logic [SQRT_W-1:0]  rad;
  logic [SQRT_H+1:0]  rem;
  logic [SQRT_CW-1:0] cnt;
  logic               busy;
  logic [SQRT_H+3:0]  remv;
  logic [SQRT_H+3:0]  trial;
  logic               take;

  assign remv  = {rem, rad[SQRT_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = remv >= trial;
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= SQRT_CW'(SQRT_H);
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy && cnt != '0) begin
      cnt  <= cnt - 1'b1;
      rad  <= rad << 2;
      rem  <= take ? (SQRT_H+2)'(remv - trial) : (SQRT_H+2)'(remv);
      root <= {root[SQRT_H-2:0], take};
    end else if (done) begin
      busy <= 1'b0;
    end
  end
endmodule

FILE: src/tbs_div.sv
// ----------------------------------------------------------------------------
// tbs_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tbs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tbs_pkg::DIV_NW-1:0] num,
  input  logic [tbs_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [tbs_pkg::DIV_NW-1:0] quo
);
  import tbs_pkg::*;

  logic [DIV_NW-1:0] n;
  logic [DIV_DW-1:0] d;
  logic [DIV_DW-1:0] rem;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   r2;
  logic              take;

  assign r2   = {rem, n[DIV_NW-1]};
  assign take = r2 >= {1'b0, d};
  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CW'(DIV_NW);
      n    <= num;
      d    <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy && cnt != '0) begin
      cnt <= cnt - 1'b1;
      n   <= n << 1;
      rem <= take ? DIV_DW'(r2 - {1'b0, d}) : DIV_DW'(r2);
      quo <= {quo[DIV_NW-2:0], take};
    end else if (done) begin
      busy <= 1'b0;
    end
  end
endmodule

FILE: src/trajectory_breakpoint_segmenter.sv
// ----------------------------------------------------------------------------
// trajectory_breakpoint_segmenter
// splits a stream of trajectory points into segments at turns and speed jumps
// ----------------------------------------------------------------------------
// Points enter on the point channel, one item per handshake; closed segments
// leave on the segment channel. Registers are written on the cfg channel,
// which is always ready: index 0 is the Q2.14 cosine threshold, index 1 the
// Q16.16 speed change threshold.
// One point is worked by a sequencer around one shared 35x35 multiplier, a
// sqrt unit and a divider. The first point of a trajectory needs only the
// length of its velocity; an interior point also takes the length and unit
// vector of its step, and each segment it closes adds the length and unit
// vector of its chord and a mean speed. point.ready is high only while idle.
// A finished segment sits in an output register; the next point is accepted
// while it waits, and the block stalls only when a second segment is ready
// before the first is taken.
// Reset restores the register defaults and starts a new trajectory.
// ----------------------------------------------------------------------------
module trajectory_breakpoint_segmenter #(
  parameter int INDEX_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  tbs_point_if.sink   point,
  tbs_seg_if.source   segment,
  tbs_cfg_if.sink     cfg
);
  import tbs_pkg::*;

  typedef enum logic [4:0] {
    IDLE, SQ, SQRT_GO, SQRT_WAIT, UNIT_GO, UNIT_WAIT, UNIT_DONE,
    SPD_MUL, SPD_GO, SPD_WAIT, CHECK, DOT, DECIDE,
    AVG_MUL, AVG_GO, AVG_WAIT, EMIT, ACCUM
  } state_t;

  typedef enum logic [1:0] {CTX_VEL, CTX_STEP, CTX_CHORD} ctx_t;

  state_t state;
  ctx_t   ctx;
  logic [1:0] j;

  logic signed [15:0] cos_thr;
  logic [31:0]        speed_thr;

  coord_t px [3];
  time_t  ts;
  logic   last;

  coord_t prev_pos [3];
  time_t  prev_ts;
  unit_t  prev_dir [3];
  logic [31:0] prev_speed;
  coord_t seg_pos [3];
  time_t  seg_ts;
  logic [INDEX_BITS:0] seg_idx;
  logic [15:0] seg_counter;
  logic [47:0] acc_len;
  logic [INDEX_BITS:0] k;

  wvec_t vec [3];
  unit_t udir [3];
  unit_t ndir [3];
  logic [SQRT_H-1:0] len;
  logic [32:0] step_len;
  logic [31:0] speed;
  logic [31:0] avg;
  logic signed [ACC_W-1:0] acc;

  coord_t eend [3];
  time_t  ets;
  logic [INDEX_BITS:0] eidx;
  logic   elast;

  logic out_valid;

  // shared multiplier
  logic signed [MUL_W-1:0] ma, mb;
  logic signed [ACC_W-1:0] prod;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      SQ: begin
        ma = MUL_W'(vec[j]);
        mb = MUL_W'(vec[j]);
      end
      SPD_MUL: begin
        ma = MUL_W'({1'b0, step_len});
        mb = US_PER_S;
      end
      AVG_MUL: begin
        ma = (j == 2'd0) ? MUL_W'({1'b0, acc_len[23:0]}) : MUL_W'({1'b0, acc_len[47:24]});
        mb = US_PER_S;
      end
      DOT: begin
        ma = MUL_W'(prev_dir[j]);
        mb = MUL_W'(ndir[j]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  // iterative units
  logic sq_start, sq_done;
  logic [SQRT_H-1:0] sq_root;
  logic div_start, div_done;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;
  logic [33:0] mag;
  logic [31:0] div_sat;

  assign mag      = vec[j] < 0 ? 34'(-vec[j]) : 34'(vec[j]);
  assign div_sat  = (|div_q[DIV_NW-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
  assign sq_start = state == SQRT_GO;
  assign div_start = (state == UNIT_GO && len != '0) || state == SPD_GO ||
                     state == AVG_GO;

  always_comb begin
    div_n = acc[DIV_NW-1:0];
    div_d = '0;
    case (state)
      UNIT_GO: begin
        div_n = DIV_NW'(mag) << 14;
        div_d = DIV_DW'(len);
      end
      SPD_GO: div_d = ts - prev_ts;
      AVG_GO: div_d = ets - seg_ts;
      default: div_d = '0;
    endcase
  end

  tbs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(acc[SQRT_W-1:0]),
    .done(sq_done), .root(sq_root)
  );

  tbs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q)
  );

  // break decision
  logic signed [33:0] dotv, cq, cc;
  logic pz, nz, brk;
  logic [31:0] ds;

  always_comb begin
    dotv = acc[33:0];
    cq   = dotv < 0 ? (dotv + 34'sd16383) >>> 14 : dotv >>> 14;
    cc   = cq > 34'sd16384 ? 34'sd16384 : (cq < -34'sd16384 ? -34'sd16384 : cq);
    pz   = prev_dir[0] == '0 && prev_dir[1] == '0 && prev_dir[2] == '0;
    nz   = ndir[0] == '0 && ndir[1] == '0 && ndir[2] == '0;
    ds   = speed > prev_speed ? speed - prev_speed : prev_speed - speed;
    brk  = (!pz && !nz && cc < 34'(cos_thr)) || ds > speed_thr;
  end

  // index clamping
  logic [INDEX_BITS-1:0] start_c, end_c;
  logic [31:0] start_w, end_w;
  logic [48:0] len_sum;

  assign start_c = seg_idx[INDEX_BITS] ? '1 : seg_idx[INDEX_BITS-1:0];
  assign end_c   = eidx[INDEX_BITS] ? '1 : eidx[INDEX_BITS-1:0];
  assign start_w = 32'(start_c);
  assign end_w   = 32'(end_c);
  assign len_sum = {1'b0, acc_len} + 49'(step_len);

  assign point.ready = state == IDLE;
  assign cfg.ready   = 1'b1;
  assign segment.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      ctx         <= CTX_VEL;
      j           <= '0;
      cos_thr     <= 16'sd14189;
      speed_thr   <= 32'd65536;
      out_valid   <= 1'b0;
      k           <= '0;
      seg_counter <= '0;
      seg_idx     <= '0;
      acc_len     <= '0;
      prev_ts     <= '0;
      prev_speed  <= '0;
      seg_ts      <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_pos[i] <= '0;
        prev_dir[i] <= '0;
        seg_pos[i]  <= '0;
      end
    end else begin
      if (state == EMIT && (!out_valid || segment.ready)) out_valid <= 1'b1;
      else if (segment.valid && segment.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        case (cfg.index)
          CFG_COS:   cos_thr   <= cfg.data[15:0];
          CFG_SPEED: speed_thr <= cfg.data;
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (point.valid) begin
            px[0] <= point.pos_x;
            px[1] <= point.pos_y;
            px[2] <= point.pos_z;
            vec[0] <= 34'(point.vel_x);
            vec[1] <= 34'(point.vel_y);
            vec[2] <= 34'(point.vel_z);
            ts    <= point.timestamp_us;
            last  <= point.last_point;
            ctx   <= CTX_VEL;
            acc   <= '0;
            j     <= '0;
            state <= SQ;
          end
        end
        SQ: begin
          acc <= acc + prod;
          if (j == 2'd2) state <= SQRT_GO;
          else j <= j + 1'b1;
        end
        SQRT_GO: state <= SQRT_WAIT;
        SQRT_WAIT: begin
          if (sq_done) begin
            len <= sq_root;
            j   <= '0;
            if (ctx == CTX_VEL) begin
              speed <= sq_root[31:0];
              if (k == '0) begin
                for (int i = 0; i < 3; i++) begin
                  prev_pos[i] <= px[i];
                  seg_pos[i]  <= px[i];
                  prev_dir[i] <= '0;
                end
                prev_ts     <= ts;
                seg_ts      <= ts;
                prev_speed  <= sq_root[31:0];
                seg_idx     <= '0;
                seg_counter <= '0;
                acc_len     <= '0;
                k           <= last ? '0 : (INDEX_BITS+1)'(1);
                state       <= IDLE;
              end else begin
                for (int i = 0; i < 3; i++)
                  vec[i] <= 34'(px[i]) - 34'(prev_pos[i]);
                ctx   <= CTX_STEP;
                acc   <= '0;
                state <= SQ;
              end
            end else begin
              state <= UNIT_GO;
            end
          end
        end
        UNIT_GO: begin
          if (len == '0) begin
            for (int i = 0; i < 3; i++) udir[i] <= '0;
            state <= UNIT_DONE;
          end else begin
            state <= UNIT_WAIT;
          end
        end
        UNIT_WAIT: begin
          if (div_done) begin
            udir[j] <= vec[j] < 0 ? -div_q[15:0] : div_q[15:0];
            if (j == 2'd2) state <= UNIT_DONE;
            else begin
              j     <= j + 1'b1;
              state <= UNIT_GO;
            end
          end
        end
        UNIT_DONE: begin
          j <= '0;
          if (ctx == CTX_STEP) begin
            step_len <= len[32:0];
            for (int i = 0; i < 3; i++) ndir[i] <= udir[i];
            if (speed == '0 && ts > prev_ts) state <= SPD_MUL;
            else state <= CHECK;
          end else begin
            state <= AVG_MUL;
          end
        end
        SPD_MUL: begin
          acc   <= prod;
          state <= SPD_GO;
        end
        SPD_GO: state <= SPD_WAIT;
        SPD_WAIT: begin
          if (div_done) begin
            speed <= div_sat;
            state <= CHECK;
          end
        end
        CHECK: begin
          j   <= '0;
          acc <= '0;
          if (k >= (INDEX_BITS+1)'(2)) state <= DOT;
          else state <= ACCUM;
        end
        DOT: begin
          acc <= acc + prod;
          if (j == 2'd2) state <= DECIDE;
          else j <= j + 1'b1;
        end
        DECIDE: begin
          if (brk) begin
            for (int i = 0; i < 3; i++) begin
              eend[i] <= prev_pos[i];
              vec[i]  <= 34'(prev_pos[i]) - 34'(seg_pos[i]);
            end
            ets   <= prev_ts;
            eidx  <= k - 1'b1;
            elast <= 1'b0;
            ctx   <= CTX_CHORD;
            acc   <= '0;
            j     <= '0;
            state <= SQ;
          end else begin
            state <= ACCUM;
          end
        end
        AVG_MUL: begin
          if (j == 2'd0) begin
            acc <= prod;
            j   <= 2'd1;
          end else begin
            acc <= acc + (prod <<< 24);
            if (ets == seg_ts) begin
              avg   <= '0;
              state <= EMIT;
            end else begin
              state <= AVG_GO;
            end
          end
        end
        AVG_GO: state <= AVG_WAIT;
        AVG_WAIT: begin
          if (div_done) begin
            avg   <= div_sat;
            state <= EMIT;
          end
        end
        EMIT: begin
          if (!out_valid || segment.ready) begin
            segment.seg_id        <= seg_counter;
            segment.first_index   <= start_w[15:0];
            segment.final_index   <= end_w[15:0];
            segment.duration_us   <= ets - seg_ts;
            segment.path_length   <= acc_len;
            segment.mean_speed    <= avg;
            segment.dir_x         <= udir[0];
            segment.dir_y         <= udir[1];
            segment.dir_z         <= udir[2];
            segment.last_segment  <= elast;
            seg_counter           <= seg_counter + 1'b1;
            if (elast) begin
              k     <= '0;
              state <= IDLE;
            end else begin
              for (int i = 0; i < 3; i++) seg_pos[i] <= eend[i];
              seg_ts  <= ets;
              seg_idx <= eidx;
              acc_len <= '0;
              state   <= ACCUM;
            end
          end
        end
        ACCUM: begin
          acc_len <= len_sum[48] ? 48'hFFFF_FFFF_FFFF : len_sum[47:0];
          if (last) begin
            for (int i = 0; i < 3; i++) begin
              eend[i] <= px[i];
              vec[i]  <= 34'(px[i]) - 34'(seg_pos[i]);
            end
            ets   <= ts;
            eidx  <= k;
            elast <= 1'b1;
            ctx   <= CTX_CHORD;
            acc   <= '0;
            j     <= '0;
            state <= SQ;
          end else begin
            for (int i = 0; i < 3; i++) begin
              prev_pos[i] <= px[i];
              prev_dir[i] <= ndir[i];
            end
            prev_ts    <= ts;
            prev_speed <= speed;
            if (!k[INDEX_BITS]) k <= k + 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule
